// ===== hw/rtl/ndl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ndl_pkg
// Types and constants shared by the nearest-neighbour downscaler with luma.
// ----------------------------------------------------------------------------
package ndl_pkg;

  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 3;
  localparam int CHAN_W    = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_BLUE_FIRST = 3'd4
  } cfg_reg_t;

  localparam logic [7:0] COEF_R = 8'd77;
  localparam logic [7:0] COEF_G = 8'd150;
  localparam logic [7:0] COEF_B = 8'd29;

  typedef struct packed {
    logic [CHAN_W-1:0] chan_a;
    logic [CHAN_W-1:0] chan_b;
    logic [CHAN_W-1:0] chan_c;
  } pix_t;

  typedef struct packed {
    logic [CHAN_W-1:0] luma;
    logic              row_end;
    logic              frame_end;
  } gray_t;

endpackage
`default_nettype wire

// ===== hw/rtl/nearest_downscale_luma.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_downscale_luma
// Picks the centre-sampled nearest source pixel for each output pixel of a
// raster stream and converts it to 8-bit luma.
// A picked pixel is registered into the output buffer when it is taken.
// Throughput: one source pixel per cycle unless stalled; the picking sums and the
// luma are worked out in the accept cycle and land in a two-entry output buffer.
// Reset clears the counters, loads all sizes with 1 and restarts the frame.
// ----------------------------------------------------------------------------
module nearest_downscale_luma #(
  parameter int MAX_DIM = 16384
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 pix_valid,
  output logic                                pix_stall,
  input  wire  ndl_pkg::pix_t                 pix_data,
  output logic                                gray_valid,
  input  wire                                 gray_stall,
  output ndl_pkg::gray_t                      gray_data,
  input  wire                                 cfg_we,
  input  wire  [ndl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [ndl_pkg::CFG_W-1:0]           cfg_data
);

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int SUM_W = $clog2((2 * MAX_DIM + 1) * MAX_DIM) + 1;
  localparam logic [ndl_pkg::CFG_W-1:0] MAX_CFG = ndl_pkg::CFG_W'(MAX_DIM);
  localparam logic [ndl_pkg::CFG_W-1:0] ONE_CFG = ndl_pkg::CFG_W'(1);

  logic [ndl_pkg::CFG_W-1:0] dst_w_raw, dst_h_raw;
  logic [DIM_W-1:0]          sw, sh, dw, dh;
  logic                      blue_first;

  logic [ndl_pkg::CFG_W-1:0] dst_w_raw_next, dst_h_raw_next;
  logic [ndl_pkg::CFG_W-1:0] sw_c, sh_c, dw_c, dh_c;
  logic [DIM_W-1:0]          sw_next, sh_next, dw_next, dh_next;
  logic                      blue_first_next;
  logic                      cfg_hit;

  logic [CNT_W-1:0] src_col, src_row, out_col, out_row;
  logic [SUM_W-1:0] col_tsum, col_esum, row_tsum, row_esum;

  logic [SUM_W-1:0] sw2, sh2, dw2, dh2;
  logic             col_hit, row_hit, col_last, row_last, pick, accept;
  logic [7:0]       red, grn, blu;
  logic [15:0]      luma_sum;
  ndl_pkg::gray_t   res_new;

  logic             skid_valid;
  ndl_pkg::gray_t   skid_data;
  logic             out_free;

  // Configuration: clamp the sizes as they are written.
  always_comb begin
    cfg_hit         = 1'b0;
    sw_c            = ndl_pkg::CFG_W'(sw);
    sh_c            = ndl_pkg::CFG_W'(sh);
    dst_w_raw_next  = dst_w_raw;
    dst_h_raw_next  = dst_h_raw;
    blue_first_next = blue_first;
    if (cfg_we) begin
      case (cfg_index)
        ndl_pkg::REG_SRC_WIDTH: begin
          cfg_hit = 1'b1;
          sw_c    = cfg_data;
        end
        ndl_pkg::REG_SRC_HEIGHT: begin
          cfg_hit = 1'b1;
          sh_c    = cfg_data;
        end
        ndl_pkg::REG_DST_WIDTH: begin
          cfg_hit        = 1'b1;
          dst_w_raw_next = cfg_data;
        end
        ndl_pkg::REG_DST_HEIGHT: begin
          cfg_hit        = 1'b1;
          dst_h_raw_next = cfg_data;
        end
        ndl_pkg::REG_BLUE_FIRST: begin
          cfg_hit         = 1'b1;
          blue_first_next = cfg_data[0];
        end
        default: cfg_hit = 1'b0;
      endcase
    end
    if (sw_c == '0) begin
      sw_c = ONE_CFG;
    end else if (sw_c > MAX_CFG) begin
      sw_c = MAX_CFG;
    end
    if (sh_c == '0) begin
      sh_c = ONE_CFG;
    end else if (sh_c > MAX_CFG) begin
      sh_c = MAX_CFG;
    end
    dw_c = dst_w_raw_next;
    if (dw_c == '0) begin
      dw_c = ONE_CFG;
    end else if (dw_c > sw_c) begin
      dw_c = sw_c;
    end
    dh_c = dst_h_raw_next;
    if (dh_c == '0) begin
      dh_c = ONE_CFG;
    end else if (dh_c > sh_c) begin
      dh_c = sh_c;
    end
    sw_next = DIM_W'(sw_c);
    sh_next = DIM_W'(sh_c);
    dw_next = DIM_W'(dw_c);
    dh_next = DIM_W'(dh_c);
  end

  // Picking and luma for the pixel at the input.
  always_comb begin
    sw2      = SUM_W'({sw, 1'b0});
    sh2      = SUM_W'({sh, 1'b0});
    dw2      = SUM_W'({dw, 1'b0});
    dh2      = SUM_W'({dh, 1'b0});
    col_hit  = col_tsum < (col_esum + dw2);
    row_hit  = row_tsum < (row_esum + dh2);
    col_last = DIM_W'(src_col) >= (sw - DIM_W'(1));
    row_last = DIM_W'(src_row) >= (sh - DIM_W'(1));
    accept   = pix_valid && !pix_stall;
    pick     = accept && col_hit && row_hit;
    red      = blue_first ? pix_data.chan_c : pix_data.chan_a;
    grn      = pix_data.chan_b;
    blu      = blue_first ? pix_data.chan_a : pix_data.chan_c;
    luma_sum = 16'(red) * 16'(ndl_pkg::COEF_R) + 16'(grn) * 16'(ndl_pkg::COEF_G)
             + 16'(blu) * 16'(ndl_pkg::COEF_B);
    res_new.luma      = luma_sum[15:8];
    res_new.row_end   = out_col == CNT_W'(dw - DIM_W'(1));
    res_new.frame_end = res_new.row_end && (out_row == CNT_W'(dh - DIM_W'(1)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_w_raw  <= ONE_CFG;
      dst_h_raw  <= ONE_CFG;
      sw         <= DIM_W'(1);
      sh         <= DIM_W'(1);
      dw         <= DIM_W'(1);
      dh         <= DIM_W'(1);
      blue_first <= 1'b0;
      src_col    <= '0;
      src_row    <= '0;
      out_col    <= '0;
      out_row    <= '0;
      col_tsum   <= SUM_W'(1);
      col_esum   <= '0;
      row_tsum   <= SUM_W'(1);
      row_esum   <= '0;
    end else if (cfg_hit) begin
      dst_w_raw  <= dst_w_raw_next;
      dst_h_raw  <= dst_h_raw_next;
      sw         <= sw_next;
      sh         <= sh_next;
      dw         <= dw_next;
      dh         <= dh_next;
      blue_first <= blue_first_next;
      src_col    <= '0;
      src_row    <= '0;
      out_col    <= '0;
      out_row    <= '0;
      col_tsum   <= SUM_W'(sw_next);
      col_esum   <= '0;
      row_tsum   <= SUM_W'(sh_next);
      row_esum   <= '0;
    end else if (accept) begin
      if (col_last) begin
        src_col  <= '0;
        out_col  <= '0;
        col_tsum <= SUM_W'(sw);
        col_esum <= '0;
        if (row_last) begin
          src_row  <= '0;
          out_row  <= '0;
          row_tsum <= SUM_W'(sh);
          row_esum <= '0;
        end else begin
          src_row  <= src_row + CNT_W'(1);
          row_esum <= row_esum + dh2;
          if (row_hit) begin
            out_row  <= out_row + CNT_W'(1);
            row_tsum <= row_tsum + sh2;
          end
        end
      end else begin
        src_col  <= src_col + CNT_W'(1);
        col_esum <= col_esum + dw2;
        if (col_hit) begin
          out_col  <= out_col + CNT_W'(1);
          col_tsum <= col_tsum + sw2;
        end
      end
    end
  end

  // Two-entry output buffer: the input is held only when both entries are full.
  assign pix_stall = skid_valid;
  assign out_free  = !gray_valid || !gray_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      gray_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        gray_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        gray_valid <= pick;
      end
    end else if (pick) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      gray_data <= skid_valid ? skid_data : res_new;
    end else if (pick) begin
      skid_data <= res_new;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> gray_valid)
    else $error("second buffer entry holds an item while the output is empty");

  a_frame_end_row_end: assert property (@(posedge clk) disable iff (rst)
    gray_valid |-> (!gray_data.frame_end || gray_data.row_end))
    else $error("frame end flagged on a pixel that does not end a row");

  a_src_col_bound: assert property (@(posedge clk) disable iff (rst)
    DIM_W'(src_col) < sw)
    else $error("source column ran past the source width");

  a_out_col_bound: assert property (@(posedge clk) disable iff (rst)
    (dw != DIM_W'(MAX_DIM)) |-> (DIM_W'(out_col) <= dw))
    else $error("more columns picked than the output width");

endmodule
`default_nettype wire
